// ----- rtl/msb_first_bit_reader_core_defines.svh -----
// ----------------------------------------------------------------------------
// MSB-first bit reader: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_READER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_READER_CORE_DEFINES_SVH

`ifndef SYNTH

// cond must hold at every clock edge
`define MBR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mbr check failed");

// cond_a at an edge implies cond_b at the same edge
`define MBR_ASSERT_IMPL(lbl, cond_a, cond_b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("mbr implication failed");

`else

`define MBR_ASSERT(lbl, cond)

`define MBR_ASSERT_IMPL(lbl, cond_a, cond_b)

`endif

`endif

// ----- rtl/mbr_pkg.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit reader package
// Sizes, operation and status codes shared by the reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbr_pkg;

    localparam int BUF_BYTES     = 4096;
    localparam int ADDR_W        = $clog2(BUF_BYTES);
    localparam int LOADED_W      = ADDR_W + 1;
    localparam int POS_W         = LOADED_W + 3;
    localparam int MAX_READ_BITS = 64;
    localparam int VALUE_W       = 64;
    localparam int REM_W         = $clog2(MAX_READ_BITS + 1);
    localparam int COUNT_W       = 16;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_READ  = 3'd1,
        OP_SKIP  = 3'd2,
        OP_ALIGN = 3'd3,
        OP_CHECK = 3'd4,
        OP_NEW   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_UNALIGNED = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/mbr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/mbr_merge.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit reader: bit merge unit
// Takes the usable bits of one buffer byte and shifts them into the value.
// ----------------------------------------------------------------------------
`default_nettype none

module mbr_merge (
    input  wire logic [mbr_pkg::VALUE_W-1:0] acc,
    input  wire logic [7:0]                  data,
    input  wire logic [2:0]                  off,
    input  wire logic [mbr_pkg::REM_W-1:0]   rem,
    output logic      [mbr_pkg::VALUE_W-1:0] acc_out,
    output logic      [mbr_pkg::REM_W-1:0]   rem_out
);

    import mbr_pkg::*;

    logic [3:0] avail;
    logic [3:0] take;
    logic [7:0] aligned;
    logic [7:0] field;

    always_comb
    begin
        avail = 4'd8 - {1'b0, off};
        if (rem < REM_W'(avail))
        begin
            take = rem[3:0];
        end
        else
        begin
            take = avail;
        end
        // drop bits already consumed, then keep the top 'take' bits
        aligned = data << off;
        field   = aligned >> (4'd8 - take);
        acc_out = (acc << take) | {{(VALUE_W - 8){1'b0}}, field};
        rem_out = rem - REM_W'(take);
    end

endmodule

`default_nettype wire

// ----- rtl/msb_first_bit_reader_core.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit reader core
// Byte buffer with a bit read position; read, skip, align, check, restart.
// ----------------------------------------------------------------------------
// Load, skip, align, check, restart, zero-bit reads and every rejected read
// write the result register at the accepting edge. A read of n bits (n > 0)
// puts its first byte address on the buffer RAM in S_FETCH, then collects
// the bytes in S_GATHER: the buffer RAM gives one byte per cycle through its
// single registered read port and the merge unit folds one byte per cycle
// into the value. The block takes no item while a read is gathering, or while
// a result waits and out_stall is high. Buffer bytes are never cleared; only
// bytes below the load count are ever merged into a value.
`default_nettype none

module msb_first_bit_reader_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    op,
    input  wire logic [7:0]                    byte_in,
    input  wire logic [mbr_pkg::COUNT_W-1:0]   num_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mbr_pkg::VALUE_W-1:0]   value,
    output logic      [2:0]                    status,
    output logic      [mbr_pkg::POS_W-1:0]     bit_pos,
    output logic      [mbr_pkg::LOADED_W-1:0]  byte_pos,
    output logic      [mbr_pkg::POS_W-1:0]     bits_left
);

    import mbr_pkg::*;

    `include "msb_first_bit_reader_core_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_GATHER
    } state_t;

    state_t               state_reg,     state_next;
    logic [POS_W-1:0]     pos_reg,       pos_next;
    logic [LOADED_W-1:0]  loaded_reg,    loaded_next;
    logic [VALUE_W-1:0]   acc_reg,       acc_next;
    logic [REM_W-1:0]     rem_reg,       rem_next;
    logic [2:0]           off_reg,       off_next;
    logic [ADDR_W-1:0]    addr_reg,      addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   value_reg,     value_next;
    logic [2:0]           status_reg,    status_next;
    logic [POS_W-1:0]     bit_pos_reg,   bit_pos_next;
    logic [LOADED_W-1:0]  byte_pos_reg,  byte_pos_next;
    logic [POS_W-1:0]     bits_left_reg, bits_left_next;

    logic                 in_accept;
    logic [POS_W-1:0]     loaded_bits;
    logic [POS_W-1:0]     left_now;
    logic                 finish_now;
    status_t              st_now;
    logic                 wr_en;
    logic [7:0]           rd_data;
    logic [VALUE_W-1:0]   merge_acc;
    logic [REM_W-1:0]     merge_rem;

    function automatic logic [POS_W-1:0] left_of(input logic [LOADED_W-1:0] loaded,
                                                 input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] tot;
        tot = {loaded, 3'b000};
        if (pos <= tot)
        begin
            return tot - pos;
        end
        return '0;
    endfunction

    mbr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (byte_in),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    mbr_merge u_merge (
        .acc     (acc_reg),
        .data    (rd_data),
        .off     (off_reg),
        .rem     (rem_reg),
        .acc_out (merge_acc),
        .rem_out (merge_rem)
    );

    assign in_stall    = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept   = in_valid && !in_stall;
    assign loaded_bits = {loaded_reg, 3'b000};
    assign left_now    = left_of(loaded_reg, pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        loaded_next    = loaded_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        off_next       = off_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        bit_pos_next   = bit_pos_reg;
        byte_pos_next  = byte_pos_reg;
        bits_left_next = bits_left_reg;
        wr_en          = 1'b0;
        finish_now     = 1'b0;
        st_now         = ST_OK;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    finish_now = 1'b1;
                    unique case (op)
                        OP_LOAD:
                        begin
                            if (loaded_reg == LOADED_W'(BUF_BYTES))
                            begin
                                st_now = ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                loaded_next = loaded_reg + 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (num_bits > COUNT_W'(MAX_READ_BITS))
                            begin
                                st_now = ST_TOO_MANY;
                            end
                            else if (left_now < num_bits)
                            begin
                                st_now = ST_UNDERFLOW;
                            end
                            else if (num_bits != '0)
                            begin
                                // multi-cycle gather; result written at the end
                                finish_now = 1'b0;
                                state_next = S_FETCH;
                                addr_next  = pos_reg[ADDR_W+2:3];
                                off_next   = pos_reg[2:0];
                                rem_next   = num_bits[REM_W-1:0];
                                acc_next   = '0;
                                pos_next   = pos_reg + num_bits;
                            end
                        end
                        OP_SKIP:
                        begin
                            if (left_now < num_bits)
                            begin
                                st_now = ST_UNDERFLOW;
                            end
                            else
                            begin
                                pos_next = pos_reg + num_bits;
                            end
                        end
                        OP_ALIGN:
                        begin
                            if (pos_reg[2:0] != 3'b000)
                            begin
                                pos_next = {pos_reg[POS_W-1:3] + 1'b1, 3'b000};
                            end
                        end
                        OP_CHECK:
                        begin
                            if (pos_reg[2:0] != 3'b000)
                            begin
                                st_now = ST_UNALIGNED;
                            end
                        end
                        OP_NEW:
                        begin
                            loaded_next = '0;
                            pos_next    = '0;
                        end
                        default:
                        begin
                            st_now = ST_OK;
                        end
                    endcase

                    if (finish_now)
                    begin
                        out_valid_next = 1'b1;
                        value_next     = '0;
                        status_next    = st_now;
                        bit_pos_next   = pos_next;
                        byte_pos_next  = pos_next[POS_W-1:3];
                        bits_left_next = left_of(loaded_next, pos_next);
                    end
                end
            end
            S_FETCH:
            begin
                // first byte address is on the RAM this cycle
                state_next = S_GATHER;
                addr_next  = addr_reg + 1'b1;
            end
            S_GATHER:
            begin
                acc_next  = merge_acc;
                rem_next  = merge_rem;
                off_next  = 3'b000;
                addr_next = addr_reg + 1'b1;
                if (merge_rem == '0)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    value_next     = merge_acc;
                    status_next    = ST_OK;
                    bit_pos_next   = pos_reg;
                    byte_pos_next  = pos_reg[POS_W-1:3];
                    bits_left_next = left_now;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            loaded_reg    <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            off_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= '0;
            bit_pos_reg   <= '0;
            byte_pos_reg  <= '0;
            bits_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            loaded_reg    <= loaded_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            off_reg       <= off_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
            bit_pos_reg   <= bit_pos_next;
            byte_pos_reg  <= byte_pos_next;
            bits_left_reg <= bits_left_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign bit_pos   = bit_pos_reg;
    assign byte_pos  = byte_pos_reg;
    assign bits_left = bits_left_reg;

    // position never runs past the loaded data
    `MBR_ASSERT(a_pos_in_range, pos_reg <= loaded_bits)
    // load count never exceeds the buffer size
    `MBR_ASSERT(a_loaded_in_range, loaded_reg <= LOADED_W'(BUF_BYTES))
    // a gather always has bits left to collect
    `MBR_ASSERT_IMPL(a_gather_rem, state_reg != S_IDLE, rem_reg != '0)
    // no pending result while a gather runs
    `MBR_ASSERT_IMPL(a_gather_out_free, state_reg != S_IDLE, !out_valid_reg)

endmodule

`default_nettype wire
